### hw/rtl/dequ_pkg.sv
package dequ_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CMD_W = 3;

  localparam int IN_BITS = CMD_W + WORD_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * WORD_W + CNT_W + 3;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_PEEK       = 3'd5
  } cmd_t;

  // Request from the control logic to the slot store for one item.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WORD_W-1:0] wdata;
    logic [IDX_W-1:0]  front_addr;
    logic [IDX_W-1:0]  back_addr;
  } mem_req_t;

  // Slot that lies offs places after base on the ring.
  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(offs);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

### hw/rtl/dequ_ctrl.sv
module dequ_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [dequ_pkg::CMD_W-1:0]  cmd,
  input  logic [dequ_pkg::WORD_W-1:0] value,
  output dequ_pkg::mem_req_t        req,
  output logic [dequ_pkg::CNT_W-1:0]  count_nxt,
  output logic                      error
);
  import dequ_pkg::*;

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r;
  logic             is_full, is_empty;
  logic [CNT_W-1:0] last_offs;

  assign is_full  = (count_r == DEPTH_CNT);
  assign is_empty = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    error      = 1'b0;
    req.we     = 1'b0;
    req.waddr  = head_r;
    req.wdata  = value;
    case (cmd_t'(cmd))
      CMD_PUSH_BACK: begin
        if (is_full) begin
          error = 1'b1;
        end else begin
          req.we    = 1'b1;
          req.waddr = ring_add(head_r, count_r[IDX_W-1:0]);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (is_full) begin
          error = 1'b1;
        end else begin
          head_nxt  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - IDX_W'(1);
          req.we    = 1'b1;
          req.waddr = head_nxt;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_POP_BACK: begin
        if (is_empty) begin
          error = 1'b1;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (is_empty) begin
          error = 1'b1;
        end else begin
          head_nxt  = ring_add(head_r, IDX_W'(1));
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    // An empty queue reads the head slot; the result masks it anyway.
    last_offs      = (count_nxt == '0) ? '0 : count_nxt - CNT_W'(1);
    req.front_addr = head_nxt;
    req.back_addr  = ring_add(head_nxt, last_offs[IDX_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### hw/rtl/dequ_store.sv
module dequ_store (
  input  logic                      clk,
  input  logic                      step,
  input  dequ_pkg::mem_req_t        req,
  output logic [dequ_pkg::WORD_W-1:0] front_word,
  output logic [dequ_pkg::WORD_W-1:0] back_word
);
  import dequ_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_front_r, rd_back_r, wdata_r;
  logic              byp_front_r, byp_back_r;

  // The reads see the slot contents before this edge's write, so a read of
  // the slot being written takes the new word from the bypass instead.
  always_ff @(posedge clk) begin
    if (step) begin
      if (req.we) begin
        mem[req.waddr] <= req.wdata;
      end
      rd_front_r  <= mem[req.front_addr];
      rd_back_r   <= mem[req.back_addr];
      wdata_r     <= req.wdata;
      byp_front_r <= req.we && (req.waddr == req.front_addr);
      byp_back_r  <= req.we && (req.waddr == req.back_addr);
    end
  end

  assign front_word = byp_front_r ? wdata_r : rd_front_r;
  assign back_word  = byp_back_r ? wdata_r : rd_back_r;

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Bounded double-ended queue of signed 32-bit words held in a ring of slots.
// A request passes the input register and then the result register before its result is valid.
// Throughput: one request per cycle while out_tready is high; the slot memory has one write port and
// two registered read ports, so every command completes in a single pass.
// Reset (rst_n low, synchronous) empties the queue and drops any request in flight.
module double_ended_queue_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata, from bit 0: command[2:0], value[31:0], zero padding
  input  logic [dequ_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata, from bit 0: front_value[31:0], back_value[31:0],
  // count[CNT_W-1:0], empty_res, full_res, error, zero padding
  output logic [dequ_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dequ_pkg::*;

  // Input register: holds one request until the result stage can take it.
  logic              a_valid_r;
  logic [CMD_W-1:0]  a_cmd_r;
  logic [WORD_W-1:0] a_val_r;

  // Result register: control fields here, the words inside the slot store.
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_error_r;

  logic              advance;
  logic              step;
  mem_req_t          req;
  logic [CNT_W-1:0]  count_nxt;
  logic              error;
  logic [WORD_W-1:0] front_word, back_word;
  logic              out_empty, out_full;
  logic [WORD_W-1:0] front_value, back_value;

  // The result stage moves on when it is empty or its result is being taken,
  // so a new request is accepted while a finished result waits if the input register is free.
  assign advance   = !out_valid_r || out_tready;
  assign step      = a_valid_r && advance;
  assign in_tready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      a_cmd_r <= in_tdata[CMD_W-1:0];
      a_val_r <= in_tdata[CMD_W +: WORD_W];
    end
  end

  // Head and count update, error detection and slot addressing.
  dequ_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cmd       (a_cmd_r),
    .value     (a_val_r),
    .req       (req),
    .count_nxt (count_nxt),
    .error     (error)
  );

  // Slot memory; its registered read data form the word half of the result.
  dequ_store u_store (
    .clk        (clk),
    .step       (step),
    .req        (req),
    .front_word (front_word),
    .back_word  (back_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_count_r <= count_nxt;
      out_error_r <= error;
    end
  end

  // An empty queue shows all ones in both word fields.
  assign out_empty   = (out_count_r == '0);
  assign out_full    = (out_count_r == DEPTH_CNT);
  assign front_value = out_empty ? EMPTY_WORD : front_word;
  assign back_value  = out_empty ? EMPTY_WORD : back_word;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_error_r, out_full, out_empty, out_count_r,
                                    back_value, front_value});

endmodule

### hw/rtl/dequ_checker.sv
module dequ_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dequ_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dequ_pkg::*;

  logic [WORD_W-1:0] chk_front, chk_back;
  logic [CNT_W-1:0]  chk_count;
  logic              chk_empty, chk_full;

  assign chk_front = out_tdata[WORD_W-1:0];
  assign chk_back  = out_tdata[2*WORD_W-1:WORD_W];
  assign chk_count = out_tdata[2*WORD_W +: CNT_W];
  assign chk_empty = out_tdata[2*WORD_W + CNT_W];
  assign chk_full  = out_tdata[2*WORD_W + CNT_W + 1];

  // The flags must agree with the count they are reported with.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_empty == (chk_count == '0)) && (chk_full == (chk_count == DEPTH_CNT)))
    else $error("empty or full flag disagrees with count");

  // An empty queue reports all ones at both ends.
  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_empty |-> (chk_front == EMPTY_WORD) && (chk_back == EMPTY_WORD))
    else $error("empty queue shows stored words");

  // With a single element, front and back are the same slot.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_count == CNT_W'(1)) |-> (chk_front == chk_back))
    else $error("single element shows different front and back");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // With no result held, nothing can block the input.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input refused while no result is held");

endmodule

bind double_ended_queue_unit dequ_checker u_dequ_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
